>>> rtl/sau_pkg.sv
package sau_pkg;

  localparam int DATA_W = 32;
  localparam int ACT_W = 3;
  localparam int STATUS_W = 2;
  localparam int DEPTH_OUT_W = 7;
  localparam int STACK_DEPTH_DEF = 64;

  localparam logic [ACT_W-1:0] ACT_PUSH = 3'd0;
  localparam logic [ACT_W-1:0] ACT_SUB  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_DIV  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_MUL  = 3'd3;
  localparam logic [ACT_W-1:0] ACT_MOD  = 3'd4;

  localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_SHORT   = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_DIVZERO = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_FULL    = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_LOAD,
    ST_DIV,
    ST_FIN
  } sau_state_t;

endpackage

>>> rtl/sau_stack_mem.sv
module sau_stack_mem #(
  parameter int DEPTH = sau_pkg::STACK_DEPTH_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [ADDR_W-1:0]         wr_addr,
  input  logic [sau_pkg::DATA_W-1:0] wr_data,
  input  logic                      rd_en,
  input  logic [ADDR_W-1:0]         rd_addr,
  output logic [sau_pkg::DATA_W-1:0] rd_data
);
  import sau_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/sau_divider.sv
module sau_divider (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [sau_pkg::DATA_W-1:0] dividend,
  input  logic [sau_pkg::DATA_W-1:0] divisor,
  output logic                       done,
  output logic [sau_pkg::DATA_W-1:0] quotient,
  output logic [sau_pkg::DATA_W-1:0] remainder
);
  import sau_pkg::*;

  localparam int CNT_W = $clog2(DATA_W);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DATA_W-1:0] quo_r, quo_nxt;
  logic [DATA_W-1:0] rem_r, rem_nxt;
  logic [DATA_W-1:0] dsr_r, dsr_nxt;
  logic [DATA_W:0]   rem_sh;
  logic [DATA_W+1:0] diff;

  // Restoring division, one quotient bit per cycle.
  assign rem_sh = {rem_r, quo_r[DATA_W-1]};
  assign diff = {1'b0, rem_sh} - {2'b00, dsr_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt = cnt_r;
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    dsr_nxt = dsr_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt = '0;
      quo_nxt = dividend;
      rem_nxt = '0;
      dsr_nxt = divisor;
    end else if (busy_r) begin
      if (!diff[DATA_W+1]) begin
        rem_nxt = diff[DATA_W-1:0];
        quo_nxt = {quo_r[DATA_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[DATA_W-1:0];
        quo_nxt = {quo_r[DATA_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(DATA_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done = done_r;
  assign quotient = quo_r;
  assign remainder = rem_r;

endmodule

>>> rtl/stack_arith_unit.sv
// Channel   Direction  Signals
// in_       input      in_valid, in_ready, in_action, in_push_value
// out_      output     out_valid, out_ready, out_status, out_top_value, out_depth
//
// One item is worked on at a time; in_ready is high only while the unit is idle.
// A push, a short-stack or full-stack error and an unknown action go from ST_DECODE
// straight to ST_FIN; subtract, multiply and a zero divisor pass through ST_LOAD, and
// divide and modulo also wait in ST_DIV for the bit-serial divider's 32 iterations.
// The result sits in an output register, so a stalled out_ready only holds back
// the next item's final write. Reset is synchronous and clears the entry count.
module stack_arith_unit #(
  parameter int STACK_DEPTH = sau_pkg::STACK_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [sau_pkg::ACT_W-1:0]           in_action,
  input  logic signed [sau_pkg::DATA_W-1:0]   in_push_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [sau_pkg::STATUS_W-1:0]        out_status,
  output logic signed [sau_pkg::DATA_W-1:0]   out_top_value,
  output logic [sau_pkg::DEPTH_OUT_W-1:0]     out_depth
);
  import sau_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  sau_state_t state_r, state_nxt;
  logic [ACT_W-1:0]       act_r, act_nxt;
  logic [DATA_W-1:0]      pv_r, pv_nxt;
  logic [STATUS_W-1:0]    stat_r, stat_nxt;
  logic [DATA_W-1:0]      res_r, res_nxt;
  logic                   sneg_r, sneg_nxt;
  logic                   tneg_r, tneg_nxt;
  logic [CW-1:0]          count_r, count_nxt;
  logic [DATA_W-1:0]      top_r, top_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]    out_status_r, out_status_nxt;
  logic [DATA_W-1:0]      out_top_r, out_top_nxt;
  logic [DEPTH_OUT_W-1:0] out_depth_r, out_depth_nxt;

  logic              wr_en, rd_en;
  logic [AW-1:0]     wr_addr, rd_addr;
  logic [DATA_W-1:0] wr_data, rd_data;
  logic              div_start, div_done;
  logic [DATA_W-1:0] div_q, div_r;
  logic [DATA_W-1:0] s_word, t_word, s_mag, t_mag, mul_lo;
  logic [CW-1:0]     cnt_m2;
  logic [CW+DEPTH_OUT_W-1:0] depth_ext;
  logic              is_arith, is_divop;

  assign s_word = rd_data;
  assign t_word = top_r;
  assign s_mag = s_word[DATA_W-1] ? (DATA_W'(0) - s_word) : s_word;
  assign t_mag = t_word[DATA_W-1] ? (DATA_W'(0) - t_word) : t_word;
  assign mul_lo = s_word * t_word;
  assign cnt_m2 = count_r - CW'(2);
  assign is_divop = (act_r == ACT_DIV) || (act_r == ACT_MOD);
  assign is_arith = (act_r == ACT_SUB) || (act_r == ACT_MUL) || is_divop;

  sau_stack_mem #(
    .DEPTH  (STACK_DEPTH),
    .ADDR_W (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  sau_divider u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (s_mag),
    .divisor   (t_mag),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  always_comb begin
    state_nxt = state_r;
    act_nxt = act_r;
    pv_nxt = pv_r;
    stat_nxt = stat_r;
    res_nxt = res_r;
    sneg_nxt = sneg_r;
    tneg_nxt = tneg_r;
    count_nxt = count_r;
    top_nxt = top_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    out_status_nxt = out_status_r;
    out_top_nxt = out_top_r;
    out_depth_nxt = out_depth_r;
    wr_en = 1'b0;
    wr_addr = '0;
    wr_data = pv_r;
    rd_en = 1'b0;
    rd_addr = '0;
    div_start = 1'b0;
    depth_ext = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          act_nxt = in_action;
          pv_nxt = in_push_value;
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        stat_nxt = STAT_OK;
        state_nxt = ST_FIN;
        if (act_r == ACT_PUSH) begin
          if (count_r >= CW'(STACK_DEPTH)) begin
            stat_nxt = STAT_FULL;
          end
        end else if (is_arith) begin
          if (count_r < CW'(2)) begin
            stat_nxt = STAT_SHORT;
          end else begin
            // The top entry is cached in top_r; only the second one is read.
            rd_en = 1'b1;
            rd_addr = cnt_m2[AW-1:0];
            state_nxt = ST_LOAD;
          end
        end
      end
      ST_LOAD: begin
        stat_nxt = STAT_OK;
        state_nxt = ST_FIN;
        if (is_divop && (t_word == '0)) begin
          stat_nxt = STAT_DIVZERO;
        end else if (act_r == ACT_SUB) begin
          res_nxt = s_word - t_word;
        end else if (act_r == ACT_MUL) begin
          res_nxt = mul_lo;
        end else begin
          div_start = 1'b1;
          sneg_nxt = s_word[DATA_W-1];
          tneg_nxt = t_word[DATA_W-1];
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          if (act_r == ACT_DIV) begin
            res_nxt = (sneg_r ^ tneg_r) ? (DATA_W'(0) - div_q) : div_q;
          end else begin
            res_nxt = sneg_r ? (DATA_W'(0) - div_r) : div_r;
          end
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          if ((stat_r == STAT_OK) && (act_r == ACT_PUSH)) begin
            wr_en = 1'b1;
            wr_addr = count_r[AW-1:0];
            wr_data = pv_r;
            count_nxt = count_r + CW'(1);
            top_nxt = pv_r;
          end else if ((stat_r == STAT_OK) && is_arith) begin
            wr_en = 1'b1;
            wr_addr = cnt_m2[AW-1:0];
            wr_data = res_r;
            count_nxt = count_r - CW'(1);
            top_nxt = res_r;
          end
          depth_ext = {{DEPTH_OUT_W{1'b0}}, count_nxt};
          out_valid_nxt = 1'b1;
          out_status_nxt = stat_r;
          out_top_nxt = (count_nxt == '0) ? '0 : top_nxt;
          out_depth_nxt = depth_ext[DEPTH_OUT_W-1:0];
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r <= act_nxt;
    pv_r <= pv_nxt;
    stat_r <= stat_nxt;
    res_r <= res_nxt;
    sneg_r <= sneg_nxt;
    tneg_r <= tneg_nxt;
    top_r <= top_nxt;
    out_status_r <= out_status_nxt;
    out_top_r <= out_top_nxt;
    out_depth_r <= out_depth_nxt;
  end

  assign in_ready = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_status = out_status_r;
  assign out_top_value = out_top_r;
  assign out_depth = out_depth_r;

endmodule

>>> rtl/sau_checker.sv
module sau_checker #(
  parameter int STACK_DEPTH = sau_pkg::STACK_DEPTH_DEF
) (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [sau_pkg::STATUS_W-1:0]      out_status,
  input logic signed [sau_pkg::DATA_W-1:0] out_top_value,
  input logic [sau_pkg::DEPTH_OUT_W-1:0]   out_depth
);
  import sau_pkg::*;

  localparam logic [DEPTH_OUT_W-1:0] FULL_DEPTH = DEPTH_OUT_W'(STACK_DEPTH);

  // A stalled result must not change under the consumer.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_top_value) && $stable(out_depth))
    else $error("result changed while stalled");

  a_empty_top: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_depth == '0) && (STACK_DEPTH < 128) |-> out_top_value == '0)
    else $error("empty stack reports a nonzero top");

  a_full_depth: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STAT_FULL) |-> out_depth == FULL_DEPTH)
    else $error("stack full reported below capacity");

  a_short_depth: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STAT_SHORT) |-> out_depth < DEPTH_OUT_W'(2))
    else $error("too few entries reported with two or more");

  // Items are taken one at a time.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while one is in flight");

endmodule

bind stack_arith_unit sau_checker #(.STACK_DEPTH(STACK_DEPTH)) u_sau_checker (.*);
